/* rtl/core/e2q_pkg.sv */
// ----------------------------------------------------------------------------
// e2q_pkg
// Shared fixed-point types, constants and the Q28 product helper for the
// Euler angle to quaternion converter.
// ----------------------------------------------------------------------------
package e2q_pkg;

    // Q28 working word: a sign bit, one integer bit and 28 fraction bits.
    localparam int QW       = 30;
    localparam int FracBits = 28;

    typedef logic signed [QW-1:0] t_q28;
    typedef logic        [QW-1:0] t_uq28;

    // Input angles carry 13 fraction bits; halving adds one more.
    localparam int InFrac     = 13;
    localparam int AngleShift = FracBits - (InFrac + 1);

    // Results carry 14 fraction bits.
    localparam int OutFrac = 14;

    // Number of Horner steps of the sine and cosine series.
    localparam int SeriesTerms = 7;

    // Register stages in one sine/cosine unit: input reduction, square,
    // two per series step, and the final sine product.
    localparam int SinCosLat = 2 * SeriesTerms + 3;

    localparam t_q28              OneQ28     = 30'sd268435456;
    localparam logic signed [QW:0] PiQ28     = 31'sd843314857;
    localparam longint            HalfPiQ28  = 64'sd421657428;
    localparam logic signed [15:0] HalfPiCode = 16'(HalfPiQ28 >> AngleShift);
    localparam logic signed [15:0] Q14One    = 16'sd16384;

    localparam logic signed [2*QW-1:0] TruncBias =
        (2*QW)'((64'sd1 <<< FracBits) - 64'sd1);

    // Q28 product, truncated toward zero.
    function automatic t_q28 mul_q28(input t_q28 a, input t_q28 b);
        logic signed [2*QW-1:0] prod;
        logic signed [2*QW-1:0] adj;
        prod = a * b;
        adj  = prod + (prod[2*QW-1] ? TruncBias : '0);
        return adj[FracBits+QW-1:FracBits];
    endfunction

endpackage

/* rtl/core/e2q_sincos.sv */
// ----------------------------------------------------------------------------
// e2q_sincos
// Pipelined sine and cosine of one half angle. The angle is folded into
// plus or minus pi/2, squared, and run through a Horner series with one
// multiply stage and one reciprocal-divide stage per term.
// ----------------------------------------------------------------------------
module e2q_sincos (
    input  logic                 i_clk,
    input  logic signed [15:0]   i_angle,
    output e2q_pkg::t_q28        o_sin,
    output e2q_pkg::t_q28        o_cos,
    output logic                 o_flip
);

    localparam int QW    = e2q_pkg::QW;
    localparam int FB    = e2q_pkg::FracBits;
    localparam int Terms = e2q_pkg::SeriesTerms;

    // ---------------- stage 0: half angle and range fold ----------------
    e2q_pkg::t_q28     r_h0;
    e2q_pkg::t_q28     n_h0;
    logic              r_flip0;
    logic              n_flip0;
    logic signed [QW:0] h_wide;
    logic signed [QW:0] h_red;

    always_comb begin
        h_wide  = {i_angle[15], i_angle, {e2q_pkg::AngleShift{1'b0}}};
        h_red   = h_wide;
        n_flip0 = 1'b0;
        if (i_angle > e2q_pkg::HalfPiCode) begin
            h_red   = h_wide - e2q_pkg::PiQ28;
            n_flip0 = 1'b1;
        end else if (i_angle < -e2q_pkg::HalfPiCode) begin
            h_red   = h_wide + e2q_pkg::PiQ28;
            n_flip0 = 1'b1;
        end
        n_h0 = h_red[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        r_h0    <= n_h0;
        r_flip0 <= n_flip0;
    end

    // ---------------- stage 1: square of the folded angle ----------------
    e2q_pkg::t_uq28 r_x2   [Terms];
    e2q_pkg::t_q28  r_h    [Terms+1];
    logic           r_flip [Terms+1];
    e2q_pkg::t_uq28 n_x2;
    logic signed [2*QW-1:0] sq;

    always_comb begin
        sq   = r_h0 * r_h0;
        n_x2 = sq[FB+QW-1:FB];
    end

    always_ff @(posedge i_clk) begin
        r_x2[0]   <= n_x2;
        r_h[0]    <= r_h0;
        r_flip[0] <= r_flip0;
    end

    // ---------------- series steps ----------------
    e2q_pkg::t_uq28 r_ms    [Terms];
    e2q_pkg::t_uq28 r_mc    [Terms];
    e2q_pkg::t_q28  r_ha    [Terms];
    logic           r_fa    [Terms];
    e2q_pkg::t_uq28 r_xa    [Terms-1];
    e2q_pkg::t_q28  r_ts    [1:Terms];
    e2q_pkg::t_q28  r_tc    [1:Terms];
    e2q_pkg::t_q28  w_ts_in [Terms];
    e2q_pkg::t_q28  w_tc_in [Terms];

    for (genvar j = 0; j < Terms; j++) begin : g_step
        localparam int K        = Terms - j;
        localparam int SinDiv   = (2 * K) * (2 * K + 1);
        localparam int CosDiv   = (2 * K - 1) * (2 * K);
        localparam int SinShift = QW + $clog2(SinDiv);
        localparam int CosShift = QW + $clog2(CosDiv);
        // Rounded-up reciprocals; exact quotients for numerators below 2^QW.
        localparam logic [63:0] SinRcpW =
            ((64'd1 << SinShift) + 64'(SinDiv) - 64'd1) / 64'(SinDiv);
        localparam logic [63:0] CosRcpW =
            ((64'd1 << CosShift) + 64'(CosDiv) - 64'd1) / 64'(CosDiv);
        localparam logic [QW:0] SinRcp = SinRcpW[QW:0];
        localparam logic [QW:0] CosRcp = CosRcpW[QW:0];

        logic [2*QW-2:0] a_ps;
        logic [2*QW-2:0] a_pc;
        e2q_pkg::t_uq28  n_ms;
        e2q_pkg::t_uq28  n_mc;
        logic [2*QW:0]   s_prod;
        logic [2*QW:0]   c_prod;
        logic [2*QW:0]   s_quo;
        logic [2*QW:0]   c_quo;
        e2q_pkg::t_q28   n_ts;
        e2q_pkg::t_q28   n_tc;

        if (j == 0) begin : g_first
            assign w_ts_in[j] = e2q_pkg::OneQ28;
            assign w_tc_in[j] = e2q_pkg::OneQ28;
        end else begin : g_next
            assign w_ts_in[j] = r_ts[j];
            assign w_tc_in[j] = r_tc[j];
        end

        // Series partial terms stay between zero and one until the last
        // cosine step, so the products here are unsigned.
        always_comb begin
            a_ps = r_x2[j] * w_ts_in[j][QW-2:0];
            a_pc = r_x2[j] * w_tc_in[j][QW-2:0];
            n_ms = a_ps[FB+QW-1:FB];
            n_mc = a_pc[FB+QW-1:FB];
        end

        always_ff @(posedge i_clk) begin
            r_ms[j] <= n_ms;
            r_mc[j] <= n_mc;
            r_ha[j] <= r_h[j];
            r_fa[j] <= r_flip[j];
        end

        always_comb begin
            s_prod = r_ms[j] * SinRcp;
            c_prod = r_mc[j] * CosRcp;
            s_quo  = s_prod >> SinShift;
            c_quo  = c_prod >> CosShift;
            n_ts   = e2q_pkg::OneQ28 - $signed({1'b0, s_quo[QW-2:0]});
            n_tc   = e2q_pkg::OneQ28 - $signed({1'b0, c_quo[QW-2:0]});
        end

        always_ff @(posedge i_clk) begin
            r_ts[j+1]   <= n_ts;
            r_tc[j+1]   <= n_tc;
            r_h[j+1]    <= r_ha[j];
            r_flip[j+1] <= r_fa[j];
        end

        if (j < Terms - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_xa[j]   <= r_x2[j];
                r_x2[j+1] <= r_xa[j];
            end
        end
    end

    // ---------------- final stage: sine from the series ----------------
    e2q_pkg::t_q28 r_sin;
    e2q_pkg::t_q28 r_cos;
    logic          r_flip_o;
    e2q_pkg::t_q28 n_sin;

    always_comb begin
        n_sin = e2q_pkg::mul_q28(r_h[Terms], r_ts[Terms]);
    end

    always_ff @(posedge i_clk) begin
        r_sin    <= n_sin;
        r_cos    <= r_tc[Terms];
        r_flip_o <= r_flip[Terms];
    end

    assign o_sin  = r_sin;
    assign o_cos  = r_cos;
    assign o_flip = r_flip_o;

endmodule

/* rtl/core/euler_to_quaternion.sv */
// ----------------------------------------------------------------------------
// euler_to_quaternion
// Yaw, pitch and roll (ZYX order) to a unit quaternion in Q14.
// ----------------------------------------------------------------------------
// The block takes one angle triple in every clock cycle: busy never rises, so
// a transaction is accepted whenever start is high. Each result appears on the
// o_quat_* ports for exactly one cycle with o_done high; the receiver must
// take it then. The result passes through the sine and cosine units, whose
// seven-term series spend one multiplier stage and one reciprocal-divide
// stage per term, followed by five stages of products, sums, magnitude and
// rounding to Q14.
module euler_to_quaternion (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [15:0] i_yaw_angle,
    input  logic signed [15:0] i_pitch_angle,
    input  logic signed [15:0] i_roll_angle,
    output logic               o_done,
    output logic signed [15:0] o_quat_w,
    output logic signed [15:0] o_quat_x,
    output logic signed [15:0] o_quat_y,
    output logic signed [15:0] o_quat_z
);

    localparam int QW        = e2q_pkg::QW;
    localparam int SumW      = QW + 1;
    localparam int RndW      = QW + 2;
    localparam int Q14Shift  = e2q_pkg::FracBits - e2q_pkg::OutFrac;
    localparam int PostLat   = 5;
    localparam int TotalLat  = e2q_pkg::SinCosLat + PostLat;
    localparam int AxisYaw   = 0;
    localparam int AxisPitch = 1;
    localparam int AxisRoll  = 2;
    // Components x and z subtract their second term.
    localparam logic [3:0] CompSub = 4'b1010;
    localparam logic [RndW-1:0] RoundHalf = RndW'(1) << (Q14Shift - 1);
    localparam logic [RndW-1:0] RndMax    = RndW'(e2q_pkg::Q14One);

    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    // ---------------- valid pipeline ----------------
    logic [TotalLat-1:0] r_vld;
    logic [TotalLat-1:0] n_vld;

    always_comb begin
        n_vld = {r_vld[TotalLat-2:0], w_accept};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_done = r_vld[TotalLat-1];

    // ---------------- sine and cosine of each half angle ----------------
    logic signed [15:0] w_angle [3];
    e2q_pkg::t_q28      w_sin   [3];
    e2q_pkg::t_q28      w_cos   [3];
    logic               w_flip  [3];

    assign w_angle[AxisYaw]   = i_yaw_angle;
    assign w_angle[AxisPitch] = i_pitch_angle;
    assign w_angle[AxisRoll]  = i_roll_angle;

    for (genvar a = 0; a < 3; a++) begin : g_axis
        e2q_sincos u_sincos (
            .i_clk   (i_clk),
            .i_angle (w_angle[a]),
            .o_sin   (w_sin[a]),
            .o_cos   (w_cos[a]),
            .o_flip  (w_flip[a])
        );
    end

    // ---------------- roll and pitch pair products ----------------
    // A folded angle negates both its sine and cosine. Truncation toward zero
    // is odd, so every term of every component carries the same sign, which
    // is applied once at the output.
    e2q_pkg::t_q28 r_crcp, r_srsp, r_srcp, r_crsp, r_cy, r_sy;
    e2q_pkg::t_q28 n_crcp, n_srsp, n_srcp, n_crsp;
    logic          r_flip_p, n_flip_p;

    always_comb begin
        n_crcp   = e2q_pkg::mul_q28(w_cos[AxisRoll], w_cos[AxisPitch]);
        n_srsp   = e2q_pkg::mul_q28(w_sin[AxisRoll], w_sin[AxisPitch]);
        n_srcp   = e2q_pkg::mul_q28(w_sin[AxisRoll], w_cos[AxisPitch]);
        n_crsp   = e2q_pkg::mul_q28(w_cos[AxisRoll], w_sin[AxisPitch]);
        n_flip_p = w_flip[AxisYaw] ^ w_flip[AxisPitch] ^ w_flip[AxisRoll];
    end

    always_ff @(posedge i_clk) begin
        r_crcp   <= n_crcp;
        r_srsp   <= n_srsp;
        r_srcp   <= n_srcp;
        r_crsp   <= n_crsp;
        r_cy     <= w_cos[AxisYaw];
        r_sy     <= w_sin[AxisYaw];
        r_flip_p <= n_flip_p;
    end

    // ---------------- triple products with yaw ----------------
    e2q_pkg::t_q28 r_ta [4];
    e2q_pkg::t_q28 r_tb [4];
    e2q_pkg::t_q28 n_ta [4];
    e2q_pkg::t_q28 n_tb [4];
    logic          r_flip_t;

    always_comb begin
        n_ta[0] = e2q_pkg::mul_q28(r_crcp, r_cy);
        n_tb[0] = e2q_pkg::mul_q28(r_srsp, r_sy);
        n_ta[1] = e2q_pkg::mul_q28(r_srcp, r_cy);
        n_tb[1] = e2q_pkg::mul_q28(r_crsp, r_sy);
        n_ta[2] = e2q_pkg::mul_q28(r_crsp, r_cy);
        n_tb[2] = e2q_pkg::mul_q28(r_srcp, r_sy);
        n_ta[3] = e2q_pkg::mul_q28(r_crcp, r_sy);
        n_tb[3] = e2q_pkg::mul_q28(r_srsp, r_cy);
    end

    always_ff @(posedge i_clk) begin
        r_ta     <= n_ta;
        r_tb     <= n_tb;
        r_flip_t <= r_flip_p;
    end

    // ---------------- component sums ----------------
    logic signed [SumW-1:0] r_sum [4];
    logic signed [SumW-1:0] n_sum [4];
    logic                   r_flip_s;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (CompSub[i]) begin
                n_sum[i] = SumW'(r_ta[i]) - SumW'(r_tb[i]);
            end else begin
                n_sum[i] = SumW'(r_ta[i]) + SumW'(r_tb[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum    <= n_sum;
        r_flip_s <= r_flip_t;
    end

    // ---------------- magnitude and final sign ----------------
    logic [SumW-1:0] r_mag  [4];
    logic [SumW-1:0] n_mag  [4];
    logic            r_qneg [4];
    logic            n_qneg [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            n_mag[i]  = r_sum[i][SumW-1] ? SumW'(-r_sum[i]) : r_sum[i];
            n_qneg[i] = r_sum[i][SumW-1] ^ r_flip_s;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_qneg <= n_qneg;
    end

    // ---------------- round half away from zero, saturate ----------------
    logic [RndW-1:0]    w_rnd [4];
    logic signed [15:0] w_sat [4];
    logic signed [15:0] r_q   [4];
    logic signed [15:0] n_q   [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_rnd[i] = (RndW'(r_mag[i]) + RoundHalf) >> Q14Shift;
            w_sat[i] = (w_rnd[i] > RndMax) ? e2q_pkg::Q14One : w_rnd[i][15:0];
            n_q[i]   = r_qneg[i] ? -w_sat[i] : w_sat[i];
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_quat_w = r_q[0];
    assign o_quat_x = r_q[1];
    assign o_quat_y = r_q[2];
    assign o_quat_z = r_q[3];

`ifndef SYNTHESIS
    // Every result traces back to exactly one accepted transaction.
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, TotalLat))
        else $error("result strobe without a matching start");

    // Saturation keeps every component within plus or minus one.
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_quat_w <= e2q_pkg::Q14One && o_quat_w >= -e2q_pkg::Q14One &&
                    o_quat_x <= e2q_pkg::Q14One && o_quat_x >= -e2q_pkg::Q14One &&
                    o_quat_y <= e2q_pkg::Q14One && o_quat_y >= -e2q_pkg::Q14One &&
                    o_quat_z <= e2q_pkg::Q14One && o_quat_z >= -e2q_pkg::Q14One))
        else $error("quaternion component outside unit range");

    // Zero angles give the identity rotation.
    a_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_yaw_angle == 16'sd0 && i_pitch_angle == 16'sd0 &&
                         i_roll_angle == 16'sd0, TotalLat))
        |-> (o_quat_w == e2q_pkg::Q14One && o_quat_x == 16'sd0 &&
             o_quat_y == 16'sd0 && o_quat_z == 16'sd0))
        else $error("zero angles did not give the identity quaternion");
`endif

endmodule

/* tb/euler_to_quaternion_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion_tb
// Drives yaw, pitch and roll angle triples into the converter with random
// idle gaps and checks every quaternion against a bit-exact fixed-point
// predictor of the ZYX half-angle product formulas.
// ----------------------------------------------------------------------------
module euler_to_quaternion_tb;

    localparam longint Q28_ONE      = 64'sd268435456;
    localparam longint PI_Q28       = 64'sd843314857;
    localparam longint HALF_PI_Q28  = 64'sd421657428;
    localparam longint Q14_FULL     = 64'sd16384;
    localparam int     SERIES_TERMS = 7;
    localparam int     DONE_LATENCY = 22;
    localparam int     IDLE_LIMIT   = 2000;
    localparam int     RANDOM_COUNT = 1400;
    localparam int     BURST_COUNT  = 64;

    localparam logic signed [15:0] HPC       = e2q_pkg::HalfPiCode;
    localparam logic signed [15:0] ANGLE_MAX = 16'sh7fff;
    localparam logic signed [15:0] ANGLE_MIN = 16'sh8000;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_quat;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic signed [15:0] i_yaw_angle;
    logic signed [15:0] i_pitch_angle;
    logic signed [15:0] i_roll_angle;
    logic               o_done;
    logic signed [15:0] o_quat_w;
    logic signed [15:0] o_quat_x;
    logic signed [15:0] o_quat_y;
    logic signed [15:0] o_quat_z;

    t_quat expected_quats[$];
    int    mismatch_count = 0;
    int    idle_cycles = 0;

    euler_to_quaternion i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_yaw_angle   (i_yaw_angle),
        .i_pitch_angle (i_pitch_angle),
        .i_roll_angle  (i_roll_angle),
        .o_done        (o_done),
        .o_quat_w      (o_quat_w),
        .o_quat_x      (o_quat_x),
        .o_quat_y      (o_quat_y),
        .o_quat_z      (o_quat_z)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Fixed-point predictor
    // ------------------------------------------------------------------------

    // Q28 product; SystemVerilog signed division truncates toward zero.
    function automatic longint q28_mul(input longint a, input longint b);
        return (a * b) / Q28_ONE;
    endfunction

    function automatic longint q28_mul3(input longint a, input longint b, input longint c);
        return q28_mul(q28_mul(a, b), c);
    endfunction

    // Half angles beyond +-pi/2 are folded back by pi, which flips both signs.
    function automatic void half_sin_cos(input longint half_q28, output longint sin_q28,
                                         output longint cos_q28);
        longint h;
        longint sign;
        longint x2;
        longint ts;
        longint tc;
        int     k;
        h    = half_q28;
        sign = 1;
        if (h > HALF_PI_Q28) begin
            h    = h - PI_Q28;
            sign = -1;
        end else if (h < -HALF_PI_Q28) begin
            h    = h + PI_Q28;
            sign = -1;
        end
        x2 = q28_mul(h, h);
        ts = Q28_ONE;
        tc = Q28_ONE;
        for (k = SERIES_TERMS; k >= 1; k--) begin
            ts = Q28_ONE - q28_mul(x2, ts) / longint'((2 * k) * (2 * k + 1));
            tc = Q28_ONE - q28_mul(x2, tc) / longint'((2 * k - 1) * (2 * k));
        end
        sin_q28 = sign * q28_mul(h, ts);
        cos_q28 = sign * tc;
    endfunction

    // Q28 to Q14, rounded half away from zero and clamped to plus or minus one.
    function automatic logic signed [15:0] round_to_q14(input longint v);
        longint mag;
        longint r;
        mag = (v < 0) ? -v : v;
        r   = (mag + 64'sd8192) / Q14_FULL;
        if (r > Q14_FULL)
            r = Q14_FULL;
        if (v < 0)
            r = -r;
        return r[15:0];
    endfunction

    function automatic t_quat zyx_quaternion(input logic signed [15:0] yaw,
                                             input logic signed [15:0] pitch,
                                             input logic signed [15:0] roll);
        longint sy, cy, sp, cp, sr, cr;
        t_quat  q;
        // The angle code read with one more fraction bit is the half angle.
        half_sin_cos(longint'(yaw) * 64'sd16384, sy, cy);
        half_sin_cos(longint'(pitch) * 64'sd16384, sp, cp);
        half_sin_cos(longint'(roll) * 64'sd16384, sr, cr);
        q.w = round_to_q14(q28_mul3(cr, cp, cy) + q28_mul3(sr, sp, sy));
        q.x = round_to_q14(q28_mul3(sr, cp, cy) - q28_mul3(cr, sp, sy));
        q.y = round_to_q14(q28_mul3(cr, sp, cy) + q28_mul3(sr, cp, sy));
        q.z = round_to_q14(q28_mul3(cr, cp, sy) - q28_mul3(sr, sp, cy));
        return q;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking and watchdog
    // ------------------------------------------------------------------------

    task automatic compare_component(input string name, input logic signed [15:0] want,
                                     input logic signed [15:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_quat want;
        if (i_rst_n && o_done) begin
            if (expected_quats.size() == 0) begin
                $error("quaternion result with no transaction outstanding");
                mismatch_count++;
            end else begin
                want = expected_quats.pop_front();
                compare_component("quat_w", want.w, o_quat_w);
                compare_component("quat_x", want.x, o_quat_x);
                compare_component("quat_y", want.y, o_quat_y);
                compare_component("quat_z", want.z, o_quat_z);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Mostly back to back or short gaps, with an occasional long pause.
    function automatic int pick_gap();
        int roll_die;
        roll_die = $urandom_range(0, 99);
        if (roll_die < 55)
            return 0;
        else if (roll_die < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 40);
    endfunction

    // Called at a rising edge; returns at the edge after the idle gap, if any.
    task automatic send_angles(input logic signed [15:0] yaw, input logic signed [15:0] pitch,
                               input logic signed [15:0] roll, input bit with_gaps);
        int gap;
        start         <= 1'b1;
        i_yaw_angle   <= yaw;
        i_pitch_angle <= pitch;
        i_roll_angle  <= roll;
        do
            @(posedge i_clk);
        while (busy);
        expected_quats.push_back(zyx_quaternion(yaw, pitch, roll));
        gap = with_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic logic signed [15:0] random_angle();
        int mode;
        mode = $urandom_range(0, 99);
        if (mode < 70)
            return 16'($urandom_range(0, 65535));
        else if (mode < 85)
            // Around the folding threshold of the half angle, either sign.
            return ($urandom_range(0, 1) ? HPC : -HPC) + 16'($urandom_range(0, 8)) - 16'sd4;
        else
            return 16'($urandom_range(0, 127)) - 16'sd64;
    endfunction

    task automatic test_extremes();
        send_angles(16'sd0, 16'sd0, 16'sd0, 1'b1);
        send_angles(ANGLE_MAX, 16'sd0, 16'sd0, 1'b1);
        send_angles(ANGLE_MIN, 16'sd0, 16'sd0, 1'b1);
        send_angles(16'sd0, ANGLE_MAX, 16'sd0, 1'b1);
        send_angles(16'sd0, ANGLE_MIN, 16'sd0, 1'b1);
        send_angles(16'sd0, 16'sd0, ANGLE_MAX, 1'b1);
        send_angles(16'sd0, 16'sd0, ANGLE_MIN, 1'b1);
        send_angles(ANGLE_MAX, ANGLE_MAX, ANGLE_MAX, 1'b1);
        send_angles(ANGLE_MIN, ANGLE_MIN, ANGLE_MIN, 1'b1);
        send_angles(16'sd1, -16'sd1, 16'sd1, 1'b1);
    endtask

    // Each axis sees the two largest codes short of the fold, HPC and HPC - 1, on both signs; none of them is folded.
    task automatic test_range_fold();
        send_angles(HPC, HPC - 16'sd1, -HPC, 1'b1);
        send_angles(-(HPC - 16'sd1), HPC, HPC - 16'sd1, 1'b1);
        send_angles(HPC - 16'sd1, -HPC, HPC, 1'b1);
        send_angles(-HPC, -(HPC - 16'sd1), -(HPC - 16'sd1), 1'b1);
    endtask

    // Half turns about one axis push a component to the clamp at plus or minus one.
    task automatic test_saturation();
        send_angles(HPC, 16'sd0, 16'sd0, 1'b1);
        send_angles(16'sd0, HPC, 16'sd0, 1'b1);
        send_angles(16'sd0, 16'sd0, HPC, 1'b1);
        send_angles(-HPC, 16'sd0, 16'sd0, 1'b1);
        send_angles(16'sd0, 16'sd0, -HPC, 1'b1);
    endtask

    task automatic test_back_to_back();
        repeat (BURST_COUNT) send_angles(random_angle(), random_angle(), random_angle(), 1'b0);
    endtask

    task automatic test_random_attitudes();
        repeat (RANDOM_COUNT) send_angles(random_angle(), random_angle(), random_angle(), 1'b1);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_yaw_angle   = '0;
        i_pitch_angle = '0;
        i_roll_angle  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_extremes();
        test_range_fold();
        test_saturation();
        test_back_to_back();
        test_random_attitudes();

        start <= 1'b0;
        while (expected_quats.size() != 0)
            @(posedge i_clk);
        repeat (DONE_LATENCY + 8) @(posedge i_clk);
        if (expected_quats.size() != 0) begin
            $error("%0d quaternion results never arrived", expected_quats.size());
            mismatch_count++;
        end

        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/e2q_pkg.sv
rtl/core/e2q_sincos.sv
rtl/core/euler_to_quaternion.sv
tb/euler_to_quaternion_tb.sv
